// ===== design/dtp_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package dtp_pkg;

    localparam int MAX_DEPTH_DEF     = 16;
    localparam int LEN_BYTES_MAX_DEF = 4;

    // event kinds
    localparam logic [2:0] KIND_PRIM  = 3'd0;
    localparam logic [2:0] KIND_CONS  = 3'd1;
    localparam logic [2:0] KIND_VALUE = 3'd2;
    localparam logic [2:0] KIND_CLOSE = 3'd3;
    localparam logic [2:0] KIND_DONE  = 3'd4;
    localparam logic [2:0] KIND_ERROR = 3'd5;

    // error codes
    localparam logic [2:0] ERR_NONE      = 3'd0;
    localparam logic [2:0] ERR_LEN_BYTES = 3'd1;
    localparam logic [2:0] ERR_PAST_END  = 3'd2;
    localparam logic [2:0] ERR_TOO_DEEP  = 3'd3;
    localparam logic [2:0] ERR_OVERRUN   = 3'd4;

    // length source for the header end computation
    localparam logic [1:0] LEN_SHORT = 2'd0;
    localparam logic [1:0] LEN_ZERO  = 2'd1;
    localparam logic [1:0] LEN_ACC   = 2'd2;

    typedef struct packed {
        logic       load;
        logic       restart;
        logic       ld_tag;
        logic       ld_cnt;
        logic       shift_len;
        logic       calc_end;
        logic [1:0] len_sel;
        logic       push;
        logic       pop;
        logic       set_vend;
        logic       inc_pos;
        logic       emit;
        logic [2:0] emit_kind;
        logic [2:0] emit_err;
        logic       flush;
    } dtp_cmd_t;

    typedef struct packed {
        logic first;
        logic byte_msb;
        logic cnt_zero;
        logic cnt_big;
        logic cnt_past;
        logic tag_past;
        logic left_one;
        logic e_past;
        logic too_deep;
        logic over_parent;
        logic constructed;
        logic len_zero;
        logic value_hit;
        logic depth_zero;
        logic top_le_q;
        logic emit_ok;
        logic flush_ok;
        logic pend_valid;
    } dtp_status_t;

endpackage
`default_nettype wire

// ===== design/dtp_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
module dtp_ctrl
    import dtp_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  dtp_status_t      st,
    output dtp_cmd_t         cmd
);

    typedef enum logic [2:0] {
        M_IDLE, M_TAG, M_LEN, M_LENX, M_VALUE, M_DONE, M_ERROR
    } mode_t;

    typedef enum logic [3:0] {
        ST_WAIT, ST_DISPATCH, ST_RUN, ST_TAGCHK, ST_LENCALC, ST_HDR,
        ST_ERR, ST_CLOSE_RD, ST_CLOSE, ST_FIN
    } state_t;

    state_t     state_reg, state_next;
    mode_t      mode_reg, mode_next;
    logic [2:0] err_reg, err_next;

    always_comb begin
        state_next = state_reg;
        mode_next  = mode_reg;
        err_next   = err_reg;
        cmd        = '0;
        s_tready   = (state_reg == ST_WAIT);
        case (state_reg)
            ST_WAIT: begin
                if (s_tvalid) begin
                    cmd.load   = 1'b1;
                    state_next = ST_DISPATCH;
                end
            end
            ST_DISPATCH: begin
                if (st.first) begin
                    cmd.restart = 1'b1;
                    mode_next   = M_TAG;
                end
                state_next = ST_RUN;
            end
            ST_RUN: begin
                case (mode_reg)
                    M_TAG: begin
                        cmd.ld_tag = 1'b1;
                        state_next = ST_TAGCHK;
                    end
                    M_LEN: begin
                        if (!st.byte_msb) begin
                            cmd.calc_end = 1'b1;
                            cmd.len_sel  = LEN_SHORT;
                            state_next   = ST_HDR;
                        end else if (st.cnt_big) begin
                            err_next   = ERR_LEN_BYTES;
                            state_next = ST_ERR;
                        end else if (st.cnt_zero) begin
                            cmd.calc_end = 1'b1;
                            cmd.len_sel  = LEN_ZERO;
                            state_next   = ST_HDR;
                        end else if (st.cnt_past) begin
                            err_next   = ERR_PAST_END;
                            state_next = ST_ERR;
                        end else begin
                            cmd.ld_cnt = 1'b1;
                            mode_next  = M_LENX;
                            state_next = ST_FIN;
                        end
                    end
                    M_LENX: begin
                        cmd.shift_len = 1'b1;
                        state_next    = st.left_one ? ST_LENCALC : ST_FIN;
                    end
                    M_VALUE: begin
                        if (st.emit_ok) begin
                            cmd.emit      = 1'b1;
                            cmd.emit_kind = KIND_VALUE;
                            state_next    = st.value_hit ? ST_CLOSE : ST_FIN;
                        end
                    end
                    default: begin
                        state_next = ST_WAIT;
                    end
                endcase
            end
            ST_TAGCHK: begin
                if (st.tag_past) begin
                    err_next   = ERR_PAST_END;
                    state_next = ST_ERR;
                end else begin
                    mode_next  = M_LEN;
                    state_next = ST_FIN;
                end
            end
            ST_LENCALC: begin
                cmd.calc_end = 1'b1;
                cmd.len_sel  = LEN_ACC;
                state_next   = ST_HDR;
            end
            ST_HDR: begin
                if (st.e_past) begin
                    err_next   = ERR_PAST_END;
                    state_next = ST_ERR;
                end else if (st.too_deep) begin
                    err_next   = ERR_TOO_DEEP;
                    state_next = ST_ERR;
                end else if (st.over_parent) begin
                    err_next   = ERR_OVERRUN;
                    state_next = ST_ERR;
                end else if (st.emit_ok) begin
                    cmd.emit      = 1'b1;
                    cmd.emit_kind = st.constructed ? KIND_CONS : KIND_PRIM;
                    cmd.push      = st.constructed;
                    if (st.len_zero) begin
                        state_next = ST_CLOSE_RD;
                    end else if (st.constructed) begin
                        mode_next  = M_TAG;
                        state_next = ST_FIN;
                    end else begin
                        cmd.set_vend = 1'b1;
                        mode_next    = M_VALUE;
                        state_next   = ST_FIN;
                    end
                end
            end
            ST_ERR: begin
                if (st.emit_ok) begin
                    cmd.emit      = 1'b1;
                    cmd.emit_kind = KIND_ERROR;
                    cmd.emit_err  = err_reg;
                    mode_next     = M_ERROR;
                    state_next    = ST_FIN;
                end
            end
            ST_CLOSE_RD: begin
                state_next = ST_CLOSE;
            end
            ST_CLOSE: begin
                if (!st.depth_zero && st.top_le_q) begin
                    if (st.emit_ok) begin
                        cmd.emit      = 1'b1;
                        cmd.emit_kind = KIND_CLOSE;
                        cmd.pop       = 1'b1;
                        state_next    = ST_CLOSE_RD;
                    end
                end else if (st.depth_zero) begin
                    if (st.emit_ok) begin
                        cmd.emit      = 1'b1;
                        cmd.emit_kind = KIND_DONE;
                        mode_next     = M_DONE;
                        state_next    = ST_FIN;
                    end
                end else begin
                    mode_next  = M_TAG;
                    state_next = ST_FIN;
                end
            end
            ST_FIN: begin
                if (!st.pend_valid || st.flush_ok) begin
                    cmd.flush   = st.pend_valid;
                    cmd.inc_pos = 1'b1;
                    state_next  = ST_WAIT;
                end
            end
            default: begin
                state_next = ST_WAIT;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_WAIT;
            mode_reg  <= M_IDLE;
            err_reg   <= ERR_NONE;
        end else begin
            state_reg <= state_next;
            mode_reg  <= mode_next;
            err_reg   <= err_next;
        end
    end

endmodule
`default_nettype wire

// ===== design/dtp_dpath.sv =====
`timescale 1ns / 1ps
`default_nettype none
module dtp_dpath
    import dtp_pkg::*;
#(
    parameter int MAX_DEPTH     = MAX_DEPTH_DEF,
    parameter int LEN_BYTES_MAX = LEN_BYTES_MAX_DEF
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic [39:0] s_tdata,
    input  wire logic        s_tuser,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [55:0]      m_tdata,
    output logic [2:0]       m_tuser,
    output logic             m_tlast,
    input  dtp_cmd_t         cmd,
    output dtp_status_t      st
);

    localparam int DEPW = $clog2(MAX_DEPTH + 1);
    localparam int AW   = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;
    localparam int LW   = $clog2(LEN_BYTES_MAX + 1);

    logic [7:0]      byte_reg;
    logic            first_reg;
    logic [31:0]     blen_reg;
    logic [7:0]      tag_reg;
    logic [31:0]     acc_reg;
    logic            ovf_reg;
    logic [LW-1:0]   left_reg;
    logic [31:0]     pos_reg;
    logic [31:0]     bend_reg;
    logic [31:0]     vend_reg;
    logic [DEPW-1:0] depth_reg;
    logic [31:0]     len_reg;
    logic            big_reg;
    logic [33:0]     e_reg;
    logic [31:0]     top_end_reg;
    logic [7:0]      top_tag_reg;

    logic [31:0] end_mem [MAX_DEPTH];
    logic [7:0]  tag_mem [MAX_DEPTH];

    // pending event and output register
    logic        pend_valid_reg;
    logic [2:0]  pend_kind_reg;
    logic [52:0] pend_data_reg;
    logic [2:0]  pend_err_reg;
    logic        out_valid_reg;
    logic [2:0]  out_kind_reg;
    logic [55:0] out_data_reg;
    logic        out_last_reg;

    logic [32:0]     pos_inc;
    logic [6:0]      cnt;
    logic [31:0]     len_sel_val;
    logic            big_sel;
    logic [AW-1:0]   rd_addr;
    logic [DEPW-1:0] depth_dec;
    logic [7:0]      ev_tag;
    logic [31:0]     ev_len;
    logic [4:0]      ev_depth;
    logic [7:0]      ev_vb;

    assign pos_inc   = {1'b0, pos_reg} + 33'd1;
    assign cnt       = byte_reg[6:0];
    assign rd_addr   = AW'(depth_reg - DEPW'(1));
    assign depth_dec = depth_reg - DEPW'(1);

    always_comb begin
        case (cmd.len_sel)
            LEN_SHORT: begin
                len_sel_val = {25'd0, byte_reg[6:0]};
                big_sel     = 1'b0;
            end
            LEN_ACC: begin
                len_sel_val = acc_reg;
                big_sel     = ovf_reg;
            end
            default: begin
                len_sel_val = 32'd0;
                big_sel     = 1'b0;
            end
        endcase
    end

    // status toward the controller
    always_comb begin
        st.first       = first_reg;
        st.byte_msb    = byte_reg[7];
        st.cnt_zero    = (cnt == 7'd0);
        st.cnt_big     = ({25'd0, cnt} > 32'(LEN_BYTES_MAX));
        st.cnt_past    = (pos_inc + {26'd0, cnt}) > {1'b0, bend_reg};
        st.tag_past    = pos_inc >= {1'b0, bend_reg};
        st.left_one    = (left_reg == LW'(1));
        st.e_past      = big_reg || (e_reg > {2'b0, bend_reg});
        st.too_deep    = (32'(depth_reg) >= 32'(MAX_DEPTH));
        st.over_parent = (depth_reg != '0) && (e_reg > {2'b0, top_end_reg});
        st.constructed = tag_reg[5];
        st.len_zero    = (len_reg == 32'd0);
        st.value_hit   = pos_inc >= {1'b0, vend_reg};
        st.depth_zero  = (depth_reg == '0);
        st.top_le_q    = {1'b0, top_end_reg} <= pos_inc;
        st.flush_ok    = !out_valid_reg || m_tready;
        st.emit_ok     = !pend_valid_reg || !out_valid_reg || m_tready;
        st.pend_valid  = pend_valid_reg;
    end

    // fields of the event being raised
    always_comb begin
        ev_tag   = tag_reg;
        ev_len   = 32'd0;
        ev_depth = 5'(depth_reg);
        ev_vb    = 8'd0;
        case (cmd.emit_kind)
            KIND_PRIM, KIND_CONS: begin
                ev_len = len_reg;
            end
            KIND_VALUE: begin
                ev_vb = byte_reg;
            end
            KIND_CLOSE: begin
                ev_tag   = top_tag_reg;
                ev_depth = 5'(depth_dec);
            end
            KIND_DONE: begin
                ev_tag   = 8'd0;
                ev_depth = 5'd0;
            end
            default: begin
                ev_tag = tag_reg;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            byte_reg  <= s_tdata[7:0];
            first_reg <= s_tuser;
            blen_reg  <= s_tdata[39:8];
        end
        if (cmd.ld_tag) begin
            tag_reg <= byte_reg;
        end
        if (cmd.ld_cnt) begin
            acc_reg  <= 32'd0;
            ovf_reg  <= 1'b0;
            left_reg <= LW'(cnt);
        end
        if (cmd.shift_len) begin
            acc_reg  <= {acc_reg[23:0], byte_reg};
            ovf_reg  <= ovf_reg || (acc_reg[31:24] != 8'd0);
            left_reg <= left_reg - LW'(1);
        end
        if (cmd.calc_end) begin
            len_reg <= len_sel_val;
            big_reg <= big_sel;
            e_reg   <= {1'b0, pos_inc} + {2'b0, len_sel_val};
        end
        if (cmd.set_vend) begin
            vend_reg <= e_reg[31:0];
        end
        if (cmd.push) begin
            end_mem[AW'(depth_reg)] <= e_reg[31:0];
            tag_mem[AW'(depth_reg)] <= tag_reg;
        end
        top_end_reg <= end_mem[rd_addr];
        top_tag_reg <= tag_mem[rd_addr];
        if (cmd.emit) begin
            pend_kind_reg <= cmd.emit_kind;
            pend_data_reg <= {ev_vb, ev_depth, ev_len, ev_tag};
            pend_err_reg  <= cmd.emit_err;
        end
        // only a real pending event moves into the output register
        if ((cmd.emit && pend_valid_reg) || cmd.flush) begin
            out_kind_reg <= pend_kind_reg;
            out_data_reg <= {pend_err_reg, pend_data_reg};
            out_last_reg <= cmd.flush;
        end
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg        <= 32'd0;
            bend_reg       <= 32'd0;
            depth_reg      <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end else begin
            if (cmd.restart) begin
                bend_reg  <= blen_reg;
                pos_reg   <= 32'd0;
                depth_reg <= '0;
            end else begin
                if (cmd.inc_pos) begin
                    pos_reg <= pos_inc[31:0];
                end
                if (cmd.push) begin
                    depth_reg <= depth_reg + DEPW'(1);
                end else if (cmd.pop) begin
                    depth_reg <= depth_dec;
                end
            end
            if (cmd.emit) begin
                pend_valid_reg <= 1'b1;
            end else if (cmd.flush) begin
                pend_valid_reg <= 1'b0;
            end
            if ((cmd.emit && pend_valid_reg) || cmd.flush) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_kind_reg;
    assign m_tlast  = out_last_reg;

endmodule
`default_nettype wire

// ===== design/der_tlv_stream_parser_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
// channel  dir  handshake            payload
// s_       in   s_tvalid/s_tready    tdata: data_byte, buffer_length; tuser: first_byte
// m_       out  m_tvalid/m_tready    tdata: tag .. error_code; tuser: event_kind; tlast
//
// each input byte is taken in ST_WAIT and passes ST_DISPATCH and ST_RUN; a byte that
// is not ignored then steps on to ST_FIN, each cascaded close passing ST_CLOSE_RD and ST_CLOSE
// events pass a pending stage and an output register; the last event of a
// byte leaves once the byte's work is finished, marked by m_tlast
// aresetn is synchronous and active low; it returns the parser to idle
// a stalled m_ side holds the parser in place; no event is lost
module der_tlv_stream_parser_core
    import dtp_pkg::*;
#(
    parameter int MAX_DEPTH     = MAX_DEPTH_DEF,
    parameter int LEN_BYTES_MAX = LEN_BYTES_MAX_DEF
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [39:0] s_tdata,   // data_byte[7:0], buffer_length[39:8]
    input  wire logic        s_tuser,   // first_byte[0]
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [55:0]      m_tdata,   // tag[7:0], elem_length[39:8], nest_depth[44:40],
                                        // value_byte[52:45], error_code[55:53]
    output logic [2:0]       m_tuser,   // event_kind[2:0]
    output logic             m_tlast    // last
);

    dtp_cmd_t    cmd;
    dtp_status_t st;

    // sequencer: parse mode and per-byte steps
    dtp_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .st       (st),
        .cmd      (cmd)
    );

    // offsets, length assembly, element stack and event registers
    dtp_dpath #(
        .MAX_DEPTH     (MAX_DEPTH),
        .LEN_BYTES_MAX (LEN_BYTES_MAX)
    ) u_dpath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast),
        .cmd      (cmd),
        .st       (st)
    );

endmodule
`default_nettype wire

// ===== design/dtp_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
module dtp_checker
    import dtp_pkg::*;
(
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        s_tvalid,
    input wire logic        s_tready,
    input wire logic [39:0] s_tdata,
    input wire logic        s_tuser,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [55:0] m_tdata,
    input wire logic [2:0]  m_tuser,
    input wire logic        m_tlast
);

    // stalled beat holds
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
            && $stable(m_tlast))
        else $error("stalled beat changed");

    // error code only on error beats
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser != KIND_ERROR |-> m_tdata[55:53] == ERR_NONE)
        else $error("error code on non-error beat");

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser == KIND_ERROR |-> m_tdata[55:53] != ERR_NONE && m_tlast)
        else $error("bad error beat");

    // done ends the byte's events
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser == KIND_DONE |-> m_tlast && m_tdata[44:40] == 5'd0)
        else $error("bad done beat");

endmodule

bind der_tlv_stream_parser_core dtp_checker u_dtp_checker (.*);
`default_nettype wire

// ===== verif/der_tlv_stream_parser_core_tb.sv =====
`timescale 1ns / 1ps
module der_tlv_stream_parser_core_tb;
    import dtp_pkg::*;

    localparam int DEPTH_LIMIT = MAX_DEPTH_DEF;
    localparam int LEN_LIMIT   = LEN_BYTES_MAX_DEF;
    localparam longint CYCLE_LIMIT = 400000;

    localparam logic [2:0] MD_IDLE  = 3'd0;
    localparam logic [2:0] MD_TAG   = 3'd1;
    localparam logic [2:0] MD_LEN   = 3'd2;
    localparam logic [2:0] MD_LENX  = 3'd3;
    localparam logic [2:0] MD_VALUE = 3'd4;
    localparam logic [2:0] MD_DONE  = 3'd5;
    localparam logic [2:0] MD_ERROR = 3'd6;

    typedef struct packed {
        logic [7:0]  data_byte;
        logic        first_byte;
        logic [31:0] buffer_length;
    } der_byte_t;

    typedef struct packed {
        logic [2:0]  kind;
        logic [7:0]  tag;
        logic [31:0] elem_length;
        logic [4:0]  nest_depth;
        logic [7:0]  value_byte;
        logic [2:0]  error_code;
        logic        last;
    } parse_event_t;

    logic aclk;
    logic aresetn;
    logic s_tvalid;
    logic s_tready;
    logic [39:0] s_tdata;
    logic s_tuser;
    logic m_tvalid;
    logic m_tready;
    logic [55:0] m_tdata;
    logic [2:0] m_tuser;
    logic m_tlast;

    der_tlv_stream_parser_core u_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .m_tlast(m_tlast)
    );

    // predictor state
    logic [2:0]  pm_mode;
    logic [7:0]  pm_tag;
    logic [63:0] pm_len_acc;
    int unsigned pm_len_left;
    logic [31:0] pm_pos;
    logic [31:0] pm_buf_end;
    logic [63:0] pm_val_end;
    int unsigned pm_depth;
    logic [63:0] pm_end_stk [DEPTH_LIMIT];
    logic [7:0]  pm_tag_stk [DEPTH_LIMIT];

    der_byte_t    byte_queue[$];
    parse_event_t event_queue[$];
    parse_event_t step_events[$];
    bit  failed;
    bit  hold_off;
    bit  no_idle;
    bit  stim_done;
    longint cycles;

    task automatic push_event(input logic [2:0] kind, input logic [7:0] tag,
                              input logic [63:0] len, input int unsigned depth,
                              input logic [7:0] vb, input logic [2:0] err);
        parse_event_t ev;
        ev.kind = kind;
        ev.tag = tag;
        ev.elem_length = len[31:0];
        ev.nest_depth = depth[4:0];
        ev.value_byte = vb;
        ev.error_code = err;
        ev.last = 1'b0;
        step_events.push_back(ev);
    endtask

    task automatic raise_error(input logic [2:0] err);
        pm_mode = MD_ERROR;
        push_event(KIND_ERROR, pm_tag, 0, pm_depth, 8'd0, err);
    endtask

    task automatic close_ended(input logic [63:0] q);
        while (pm_depth > 0 && pm_end_stk[pm_depth-1] <= q) begin
            pm_depth--;
            push_event(KIND_CLOSE, pm_tag_stk[pm_depth], 0, pm_depth, 8'd0, ERR_NONE);
        end
        if (pm_depth == 0) begin
            pm_mode = MD_DONE;
            push_event(KIND_DONE, 8'd0, 0, 0, 8'd0, ERR_NONE);
        end else begin
            pm_mode = MD_TAG;
        end
    endtask

    task automatic finish_header(input logic [63:0] len);
        logic [63:0] d;
        logic [63:0] e;
        d = {32'd0, pm_pos} + 64'd1;
        e = d + len;
        if (len > 64'hFFFF_FFFF || e > {32'd0, pm_buf_end}) raise_error(ERR_PAST_END);
        else if (pm_depth >= DEPTH_LIMIT) raise_error(ERR_TOO_DEEP);
        else if (pm_depth > 0 && e > pm_end_stk[pm_depth-1]) raise_error(ERR_OVERRUN);
        else if (pm_tag[5]) begin
            push_event(KIND_CONS, pm_tag, len, pm_depth, 8'd0, ERR_NONE);
            pm_end_stk[pm_depth] = e;
            pm_tag_stk[pm_depth] = pm_tag;
            pm_depth++;
            if (len == 0) close_ended(d);
            else pm_mode = MD_TAG;
        end else begin
            push_event(KIND_PRIM, pm_tag, len, pm_depth, 8'd0, ERR_NONE);
            if (len == 0) close_ended(d);
            else begin
                pm_val_end = e;
                pm_mode = MD_VALUE;
            end
        end
    endtask

    // predicts the events caused by one accepted byte
    task automatic predict_byte(input der_byte_t it);
        logic [7:0] b;
        int unsigned cnt;
        bit active;
        b = it.data_byte;
        active = 1;
        step_events.delete();
        if (it.first_byte) begin
            pm_buf_end = it.buffer_length;
            pm_pos = 0;
            pm_depth = 0;
            pm_len_acc = 0;
            pm_len_left = 0;
            pm_val_end = 0;
            pm_tag = 0;
            pm_mode = MD_TAG;
        end
        case (pm_mode)
            MD_TAG: begin
                pm_tag = b;
                if ({32'd0, pm_pos} + 1 >= {32'd0, pm_buf_end}) raise_error(ERR_PAST_END);
                else pm_mode = MD_LEN;
            end
            MD_LEN: begin
                if (!b[7]) finish_header({57'd0, b[6:0]});
                else begin
                    cnt = {25'd0, b[6:0]};
                    if (cnt > LEN_LIMIT) raise_error(ERR_LEN_BYTES);
                    else if (cnt == 0) finish_header(0);
                    else if ({32'd0, pm_pos} + 1 + cnt > {32'd0, pm_buf_end})
                        raise_error(ERR_PAST_END);
                    else begin
                        pm_len_acc = 0;
                        pm_len_left = cnt;
                        pm_mode = MD_LENX;
                    end
                end
            end
            MD_LENX: begin
                pm_len_acc = (pm_len_acc << 8) | {56'd0, b};
                if (pm_len_left > 0) pm_len_left--;
                if (pm_len_left == 0) finish_header(pm_len_acc);
            end
            MD_VALUE: begin
                push_event(KIND_VALUE, pm_tag, 0, pm_depth, b, ERR_NONE);
                if ({32'd0, pm_pos} + 1 >= pm_val_end) close_ended({32'd0, pm_pos} + 1);
            end
            default: active = 0;
        endcase
        if (active) begin
            pm_pos = pm_pos + 1;
            if (step_events.size() > 0) step_events[$].last = 1'b1;
            foreach (step_events[i]) event_queue.push_back(step_events[i]);
        end
    endtask

    // stimulus building helpers
    task automatic add_byte(input logic [7:0] b, input bit first, input logic [31:0] blen);
        der_byte_t it;
        it.data_byte = b;
        it.first_byte = first;
        it.buffer_length = blen;
        byte_queue.push_back(it);
    endtask

    // random tree appended to a byte list; a body too long for its length bytes makes it malformed
    function automatic void gen_tlv(ref logic [7:0] buf_bytes[$], input int lvl);
        logic [7:0] tg;
        logic [7:0] body[$];
        int n;
        int len;
        tg = 8'($urandom_range(0, 255));
        if (lvl >= 3 || $urandom_range(0, 2) == 0) begin
            tg[5] = 1'b0;
            n = $urandom_range(0, 5);
            for (int i = 0; i < n; i++) body.push_back(8'($urandom_range(0, 255)));
        end else begin
            tg[5] = 1'b1;
            n = $urandom_range(0, 3);
            for (int i = 0; i < n; i++) gen_tlv(body, lvl + 1);
        end
        len = body.size();
        buf_bytes.push_back(tg);
        case ($urandom_range(0, 3))
            0: buf_bytes.push_back(8'h81);
            1: begin
                buf_bytes.push_back(8'h82);
                buf_bytes.push_back(8'h00);
            end
            2: begin
                buf_bytes.push_back(8'h84);
                buf_bytes.push_back(8'h00);
                buf_bytes.push_back(8'h00);
                buf_bytes.push_back(8'h00);
            end
            default: ;
        endcase
        if (len == 0 && $urandom_range(0, 3) == 0 && buf_bytes[$] == tg)
            buf_bytes.push_back(8'h80);
        else
            buf_bytes.push_back(len[7:0] & (buf_bytes[$] == tg ? 8'h7F : 8'hFF));
        foreach (body[i]) buf_bytes.push_back(body[i]);
    endfunction

    task automatic add_buffer(input logic [7:0] bytes[$], input logic [31:0] blen);
        foreach (bytes[i]) add_byte(bytes[i], i == 0, blen);
    endtask

    task automatic build_directed();
        logic [7:0] bb[$];
        // byte before any buffer is ignored
        add_byte(8'hFF, 1'b0, 32'hFFFF_FFFF);
        // constructed holding primitive, then trailing byte ignored
        bb = '{8'h30, 8'h03, 8'h02, 8'h01, 8'hFF, 8'h00};
        add_buffer(bb, 32'd5);
        // long form length and zero-length constructed root
        bb = '{8'h04, 8'h82, 8'h00, 8'h01, 8'h00};
        add_buffer(bb, 32'd5);
        bb = '{8'h20, 8'h80};
        add_buffer(bb, 32'd2);
        // too many length bytes
        bb = '{8'h04, 8'h85};
        add_buffer(bb, 32'hFFFF_FFFF);
        // tag as last byte of buffer, and buffer length zero
        add_byte(8'h04, 1'b1, 32'd1);
        add_byte(8'h05, 1'b1, 32'd0);
        // length past buffer end
        bb = '{8'h04, 8'h7F};
        add_buffer(bb, 32'd3);
        bb = '{8'h04, 8'h84};
        add_buffer(bb, 32'd4);
        // child overruns parent
        bb = '{8'hE0, 8'h02, 8'h04, 8'h01};
        add_buffer(bb, 32'd10);
        // restart mid-buffer
        add_byte(8'h3F, 1'b1, 32'd20);
    endtask

    task automatic build_deep(input int lvls);
        logic [7:0] bb[$];
        for (int i = 0; i < lvls; i++) begin
            bb.push_back(8'h30);
            bb.push_back(8'(2 * (lvls - 1 - i)));
        end
        if (lvls > DEPTH_LIMIT) begin
            for (int i = 0; i < lvls; i++) bb[2*i+1] = 8'(2 * (lvls - 1 - i));
        end
        add_buffer(bb, bb.size());
    endtask

    task automatic build_random(input int target);
        logic [7:0] bb[$];
        int start;
        int r;
        start = byte_queue.size();
        while (byte_queue.size() - start < target) begin
            bb.delete();
            r = $urandom_range(0, 99);
            if (r < 70) begin
                gen_tlv(bb, 0);
                add_buffer(bb, bb.size());
            end else if (r < 85) begin
                gen_tlv(bb, 0);
                if (bb.size() > 1)
                    bb[$urandom_range(1, bb.size() - 1)] = 8'($urandom_range(0, 255));
                add_buffer(bb, $urandom_range(0, 1) ? bb.size() : $urandom_range(0, 40));
            end else begin
                for (int i = 0; i < $urandom_range(1, 8); i++)
                    bb.push_back(8'($urandom_range(0, 255)));
                add_buffer(bb, $urandom);
                add_byte(8'($urandom_range(0, 255)), 1'b0, $urandom);
            end
        end
    endtask

    // clock and reset
    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    initial begin
        aresetn = 1'b0;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
    end

    // predictor reset state
    initial begin
        pm_mode = MD_IDLE;
        pm_tag = 0;
        pm_len_acc = 0;
        pm_len_left = 0;
        pm_pos = 0;
        pm_buf_end = 0;
        pm_val_end = 0;
        pm_depth = 0;
        failed = 0;
        hold_off = 0;
        no_idle = 0;
        stim_done = 0;
        cycles = 0;
    end

    // stimulus sequencing, with one pause until all events drain
    initial begin
        build_directed();
        build_deep(DEPTH_LIMIT);
        build_deep(DEPTH_LIMIT + 1);
        @(posedge aclk iff aresetn);
        wait (byte_queue.size() == 0);
        hold_off = 1;
        wait (event_queue.size() == 0);
        hold_off = 0;
        no_idle = 1;
        build_random(90);
        wait (byte_queue.size() == 0);
        no_idle = 0;
        build_random(220);
        wait (byte_queue.size() == 0);
        stim_done = 1;
    end

    // driver: head of queue presented on s_, popped on acceptance
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
            s_tuser  <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                predict_byte(byte_queue.pop_front());
            end
            if (!(s_tvalid && !s_tready)) begin
                if (byte_queue.size() > 0 && !hold_off &&
                    (no_idle || $urandom_range(0, 99) >= 32)) begin
                    s_tvalid <= 1'b1;
                    s_tdata  <= {byte_queue[0].buffer_length, byte_queue[0].data_byte};
                    s_tuser  <= byte_queue[0].first_byte;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // monitor: compare each event beat against the oldest prediction
    always @(posedge aclk) begin
        parse_event_t exp_ev;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (event_queue.size() == 0) begin
                    $error("unexpected event beat kind=%0d", m_tuser);
                    failed = 1;
                end else begin
                    exp_ev = event_queue.pop_front();
                    if (m_tuser !== exp_ev.kind) begin
                        $error("event_kind exp %0d got %0d", exp_ev.kind, m_tuser);
                        failed = 1;
                    end
                    if (m_tdata[7:0] !== exp_ev.tag) begin
                        $error("tag exp %0h got %0h", exp_ev.tag, m_tdata[7:0]);
                        failed = 1;
                    end
                    if (m_tdata[39:8] !== exp_ev.elem_length) begin
                        $error("elem_length exp %0h got %0h", exp_ev.elem_length, m_tdata[39:8]);
                        failed = 1;
                    end
                    if (m_tdata[44:40] !== exp_ev.nest_depth) begin
                        $error("nest_depth exp %0d got %0d", exp_ev.nest_depth, m_tdata[44:40]);
                        failed = 1;
                    end
                    if (m_tdata[52:45] !== exp_ev.value_byte) begin
                        $error("value_byte exp %0h got %0h", exp_ev.value_byte, m_tdata[52:45]);
                        failed = 1;
                    end
                    if (m_tdata[55:53] !== exp_ev.error_code) begin
                        $error("error_code exp %0d got %0d", exp_ev.error_code, m_tdata[55:53]);
                        failed = 1;
                    end
                    if (m_tlast !== exp_ev.last) begin
                        $error("last exp %0b got %0b", exp_ev.last, m_tlast);
                        failed = 1;
                    end
                end
            end
            m_tready <= no_idle || ($urandom_range(0, 99) >= 32);
        end
    end

    // end of run and timeout
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    initial begin
        wait (stim_done);
        wait (event_queue.size() == 0 && !(s_tvalid));
        repeat (200) @(posedge aclk);
        if (!failed && event_queue.size() == 0) begin
            $display("Regression PASS");
        end else begin
            if (event_queue.size() != 0) $error("%0d events never arrived", event_queue.size());
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
